// ===== src/b64x_pkg.sv =====
package b64x_pkg;

  // Largest key the block holds, in bytes.
  localparam logic [4:0] KeyBytes = 5'd16;

  // Results one input item can cause at most.
  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] CharPad   = 8'h3d;  // '='
  localparam logic [7:0] CharPlus  = 8'h2b;  // '+'
  localparam logic [7:0] CharSlash = 8'h2f;  // '/'
  localparam logic [7:0] CharUpperA = 8'h41; // 'A'
  localparam logic [7:0] CharUpperZ = 8'h5a; // 'Z'
  localparam logic [7:0] CharLowerA = 8'h61; // 'a'
  localparam logic [7:0] CharLowerZ = 8'h7a; // 'z'
  localparam logic [7:0] CharDigit0 = 8'h30; // '0'
  localparam logic [7:0] CharDigit9 = 8'h39; // '9'

  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MODE       = 2'd0,
    CFG_KEY_LENGTH = 2'd1,
    CFG_KEY_LOW    = 2'd2,
    CFG_KEY_HIGH   = 2'd3
  } cfg_reg_e;

  // One queued result.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } result_t;

  // Maps a sextet onto its base64 character.
  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] ch;
    if (s < 6'd26) begin
      ch = CharUpperA + {2'b00, s};
    end else if (s < 6'd52) begin
      ch = CharLowerA + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      ch = CharDigit0 + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      ch = CharPlus;
    end else begin
      ch = CharSlash;
    end
    return ch;
  endfunction

  // Maps a character onto {in alphabet, sextet}.
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      r = {1'b1, 6'(c - CharUpperA)};
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      r = {1'b1, 6'(c - CharLowerA + 8'd26)};
    end else if (c >= CharDigit0 && c <= CharDigit9) begin
      r = {1'b1, 6'(c - CharDigit0 + 8'd52)};
    end else if (c == CharPlus) begin
      r = {1'b1, 6'd62};
    end else if (c == CharSlash) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

  // Steps a key position, wrapping at the length in use.
  function automatic logic [3:0] next_pos(input logic [3:0] p, input logic [4:0] len);
    logic [4:0] p1;
    p1 = {1'b0, p} + 5'd1;
    return (p1 >= len) ? 4'd0 : p1[3:0];
  endfunction

endpackage

// ===== src/base64_xor_cipher.sv =====
// Streaming base64 codec with a repeating XOR key.
// Bytes enter on the s_axis channel, one per transfer, with tlast on the final
// byte of a message. Results leave on the m_axis channel, one per transfer:
// tdata carries the character or decoded byte, tuser says whether tdata holds
// a byte (low for the empty end marker of a decrypted message), and tlast marks
// the final result of the message.
// Registers are written through the cfg channel (index, 64-bit data), which is
// always ready. Writes are meant to happen while the block is idle; writing the
// mode or the key length also clears the open group and the key position.
// Each accepted byte is processed in the cycle of its transfer, and its results
// (zero to four) are loaded into a four-entry result queue, so the first result
// shows on m_axis in the cycle after the input transfer. The queue drains one
// result per cycle while the receiver is ready, and a new byte is taken as soon
// as the queue is empty or its final entry is leaving in the same cycle.
// Encrypting yields one four-character group every three bytes, or one result
// per byte with an empty key. When decrypting, a character that causes two or
// three results holds off the next character while those results drain.
// When the receiver stalls, the queue holds its entries and s_axis_tready_o
// falls, so nothing is lost. Reset clears the registers, the group state and
// the queue.
module base64_xor_cipher
  import b64x_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_in
  input  logic        s_axis_tlast_i,   // last_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // data_out
  output logic        m_axis_tuser_o,   // data_valid
  output logic        m_axis_tlast_o,   // last_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // Configuration registers.
  mode_e       mode_q;
  logic [4:0]  key_len_q;
  logic [63:0] key_low_q;
  logic [63:0] key_high_q;

  // Group state.
  logic [23:0] grp_q, grp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [3:0]  pos_q, pos_d;
  logic        stop_q, stop_d;

  // Result queue; entry 0 is the head.
  result_t     res_q [MaxResults];
  result_t     res_d [MaxResults];
  logic [2:0]  res_cnt_q;
  logic [2:0]  n_new;

  logic        in_fire, out_fire, cfg_fire, cfg_clear;
  logic [127:0] key_all;
  logic [4:0]  len;
  logic [3:0]  kp [MaxResults+1];
  logic [7:0]  kb [MaxResults];

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign cfg_clear   = cfg_fire && (cfg_reg_e'(cfg_index_i) == CFG_MODE ||
                                    cfg_reg_e'(cfg_index_i) == CFG_KEY_LENGTH);

  assign m_axis_tvalid_o = (res_cnt_q != 3'd0);
  assign m_axis_tdata_o  = res_q[0].data;
  assign m_axis_tuser_o  = res_q[0].valid;
  assign m_axis_tlast_o  = res_q[0].last;
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;

  // Take a new byte once the queue is empty or its last entry is leaving.
  assign s_axis_tready_o = (res_cnt_q == 3'd0) || (res_cnt_q == 3'd1 && m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign key_all = {key_high_q, key_low_q};
  assign len     = (key_len_q > KeyBytes) ? KeyBytes : key_len_q;

  // Key positions for up to four consecutive characters; a stale position
  // at or past the length starts over at zero.
  always_comb begin
    kp[0] = ({1'b0, pos_q} >= len) ? 4'd0 : pos_q;
    for (int i = 0; i < MaxResults; i++) begin
      kp[i+1] = next_pos(kp[i], len);
      kb[i]   = key_all[kp[i]*8 +: 8];
    end
  end

  always_comb begin
    logic [23:0] buf24;
    logic [2:0]  c;
    logic [7:0]  ch;
    logic [6:0]  sx;
    logic        last;
    buf24  = grp_q;
    c      = {1'b0, cnt_q};
    ch     = '0;
    sx     = '0;
    last   = s_axis_tlast_i;
    grp_d  = grp_q;
    cnt_d  = cnt_q;
    pos_d  = pos_q;
    stop_d = stop_q;
    n_new  = 3'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res_d[i] = '0;
    end

    if (mode_q == MODE_ENCRYPT) begin
      if (len == 5'd0) begin
        // No key: the byte passes through as is.
        res_d[0] = '{data: s_axis_tdata_i, valid: 1'b1, last: last};
        n_new    = 3'd1;
      end else begin
        if (c > 3'd2) begin
          c = 3'd2;
        end
        case (c)
          3'd0:    buf24[23:16] = s_axis_tdata_i;
          3'd1:    buf24[15:8]  = s_axis_tdata_i;
          default: buf24[7:0]   = s_axis_tdata_i;
        endcase
        c = c + 3'd1;
        if (c == 3'd3 || last) begin
          for (int j = 0; j < MaxResults; j++) begin
            ch = (3'(j) <= c) ? sextet_to_char(buf24[23-6*j -: 6]) : CharPad;
            res_d[j] = '{data: ch ^ kb[j], valid: 1'b1, last: last && (j == 3)};
          end
          n_new = 3'd4;
          pos_d = kp[4];
          buf24 = '0;
          c     = 3'd0;
        end
        grp_d = buf24;
        cnt_d = c[1:0];
      end
    end else begin
      ch = s_axis_tdata_i ^ ((len == 5'd0) ? 8'd0 : kb[0]);
      if (len != 5'd0) begin
        pos_d = kp[1];
      end
      if (!stop_q) begin
        sx = char_to_sextet(ch);
        if (!sx[6]) begin
          stop_d = 1'b1;
        end else begin
          case (cnt_q)
            2'd0:    buf24[23:18] = sx[5:0];
            2'd1:    buf24[17:12] = sx[5:0];
            2'd2:    buf24[11:6]  = sx[5:0];
            default: buf24[5:0]   = sx[5:0];
          endcase
          c = c + 3'd1;
          if (c == 3'd4) begin
            res_d[0] = '{data: buf24[23:16], valid: 1'b1, last: 1'b0};
            res_d[1] = '{data: buf24[15:8],  valid: 1'b1, last: 1'b0};
            res_d[2] = '{data: buf24[7:0],   valid: 1'b1, last: 1'b0};
            n_new    = 3'd3;
            buf24    = '0;
            c        = 3'd0;
          end
        end
      end
      if (last) begin
        // Flush a partial group of two or three sextets.
        if (c >= 3'd2) begin
          res_d[n_new[1:0]] = '{data: buf24[23:16], valid: 1'b1, last: 1'b0};
          n_new = n_new + 3'd1;
        end
        if (c >= 3'd3) begin
          res_d[n_new[1:0]] = '{data: buf24[15:8], valid: 1'b1, last: 1'b0};
          n_new = n_new + 3'd1;
        end
        if (n_new == 3'd0) begin
          res_d[0] = '{data: 8'd0, valid: 1'b0, last: 1'b1};
          n_new    = 3'd1;
        end else begin
          res_d[n_new[1:0] - 2'd1].last = 1'b1;
        end
      end
      grp_d = buf24;
      cnt_d = c[1:0];
    end

    // The end of a message returns the group state to zero.
    if (last) begin
      grp_d  = '0;
      cnt_d  = '0;
      pos_d  = '0;
      stop_d = 1'b0;
    end
  end

  // Configuration registers and group state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_ENCRYPT;
      key_len_q  <= '0;
      key_low_q  <= '0;
      key_high_q <= '0;
      grp_q      <= '0;
      cnt_q      <= '0;
      pos_q      <= '0;
      stop_q     <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_MODE:       mode_q     <= mode_e'(cfg_data_i[0]);
          CFG_KEY_LENGTH: key_len_q  <= cfg_data_i[4:0];
          CFG_KEY_LOW:    key_low_q  <= cfg_data_i;
          CFG_KEY_HIGH:   key_high_q <= cfg_data_i;
          default:        key_high_q <= key_high_q;
        endcase
      end
      if (cfg_clear) begin
        grp_q  <= '0;
        cnt_q  <= '0;
        pos_q  <= '0;
        stop_q <= 1'b0;
      end else if (in_fire) begin
        grp_q  <= grp_d;
        cnt_q  <= cnt_d;
        pos_q  <= pos_d;
        stop_q <= stop_d;
      end
    end
  end

  // Result queue occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= '0;
    end else if (in_fire) begin
      res_cnt_q <= n_new;
    end else if (out_fire) begin
      res_cnt_q <= res_cnt_q - 3'd1;
    end
  end

  // Result queue payload: load on an input transfer, else shift on output.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < MaxResults; i++) begin
        res_q[i] <= res_d[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import b64x_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned MaxReports = 10;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned SettleCycles = 4;

  // The standard base64 alphabet, indexed by sextet.
  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Clock and the one reset at the start of the run.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Byte stream into the block.
  logic       s_valid = 1'b0;
  logic [7:0] s_data = 8'h00;
  logic       s_last = 1'b0;
  logic       s_ready;

  // Result stream out of the block.
  logic       m_valid;
  logic       m_ready = 1'b0;
  logic [7:0] m_data;
  logic       m_user;
  logic       m_last;

  // Register write channel.
  logic        cfg_valid = 1'b0;
  cfg_reg_e    cfg_index = CFG_MODE;
  logic [63:0] cfg_data = 64'd0;
  logic        cfg_ready;

  // Pacing controls. While steady is set neither side idles at random. Flipping
  // hold_req makes the receiver hold off until hold_left, loaded from HoldCycles, runs out.
  logic        steady = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  // Settings as the stimulus side wrote them; used to build cipher text.
  logic [4:0]   plan_len = 5'd0;
  logic [127:0] plan_key = 128'd0;

  // Predictor copy of the registers and of the codec state.
  mode_e        cdc_mode = MODE_ENCRYPT;
  logic [4:0]   cdc_key_len = 5'd0;
  logic [63:0]  cdc_key_low = 64'd0;
  logic [63:0]  cdc_key_high = 64'd0;
  logic [23:0]  grp_bits = 24'd0;
  logic [1:0]   grp_cnt = 2'd0;
  logic [3:0]   key_pos = 4'd0;
  logic         dec_stopped = 1'b0;

  result_t      expected_out_q[$];
  int unsigned  sent_items = 0;
  int unsigned  predicted_items = 0;
  int unsigned  mismatches = 0;

  base64_xor_cipher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // 12 ns clock period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic result_t make_result(logic [7:0] d, logic v, logic l);
    result_t r;
    r.data = d;
    r.valid = v;
    r.last = l;
    return r;
  endfunction

  function automatic void clear_codec_state();
    grp_bits = 24'd0;
    grp_cnt = 2'd0;
    key_pos = 4'd0;
    dec_stopped = 1'b0;
  endfunction

  // Key lengths above the key store size behave as the full key.
  function automatic int unsigned active_key_len();
    return (cdc_key_len > KeyBytes) ? int'(KeyBytes) : int'(cdc_key_len);
  endfunction

  // Returns the key byte for the current position and steps the position.
  // A position at or beyond the active length restarts from byte zero.
  function automatic logic [7:0] advance_key();
    int unsigned len;
    int unsigned pos;
    logic [127:0] key;
    logic [7:0] kb;
    len = active_key_len();
    if (len == 0) return 8'h00;
    key = {cdc_key_high, cdc_key_low};
    pos = key_pos;
    if (pos >= len) pos = 0;
    kb = key[8*pos +: 8];
    pos++;
    if (pos >= len) pos = 0;
    key_pos = 4'(pos);
    return kb;
  endfunction

  // Sextet of a base64 character, or -1 for anything outside the alphabet.
  function automatic int sextet_value(logic [7:0] c);
    if (c >= CharUpperA && c <= CharUpperZ) return int'(c - CharUpperA);
    if (c >= CharLowerA && c <= CharLowerZ) return int'(c - CharLowerA) + 26;
    if (c >= CharDigit0 && c <= CharDigit9) return int'(c - CharDigit0) + 52;
    if (c == CharPlus) return 62;
    if (c == CharSlash) return 63;
    return -1;
  endfunction

  task automatic apply_reg_write(input cfg_reg_e idx, input logic [63:0] value);
    case (idx)
      CFG_MODE: begin
        cdc_mode = mode_e'(value[0]);
        clear_codec_state();
      end
      CFG_KEY_LENGTH: begin
        cdc_key_len = value[4:0];
        clear_codec_state();
      end
      CFG_KEY_LOW: cdc_key_low = value;
      CFG_KEY_HIGH: cdc_key_high = value;
      default: ;
    endcase
  endtask

  // Works out the results of one accepted byte and queues them.
  task automatic predict_codec_item(input logic [7:0] d, input logic l);
    result_t batch[$];
    int unsigned cnt;
    logic [23:0] bits;
    logic [7:0] ch;
    int v;
    cnt = grp_cnt;
    bits = grp_bits;
    if (cdc_mode == MODE_ENCRYPT) begin
      if (active_key_len() == 0) begin
        // Without a key the byte goes straight through, no encoding.
        batch.push_back(make_result(d, 1'b1, l));
      end else begin
        if (cnt > 2) cnt = 2;
        bits |= 24'(d) << (16 - 8 * cnt);
        cnt++;
        if (cnt == 3 || l) begin
          // Characters beyond the bytes present become padding.
          for (int j = 0; j < 4; j++) begin
            ch = (j <= cnt) ? b64_alphabet[bits[18-6*j +: 6]] : CharPad;
            batch.push_back(make_result(ch ^ advance_key(), 1'b1, l && j == 3));
          end
          bits = 24'd0;
          cnt = 0;
        end
      end
    end else begin
      // The key always advances, even once decoding has stopped.
      ch = d ^ advance_key();
      if (!dec_stopped) begin
        v = sextet_value(ch);
        if (v < 0) begin
          dec_stopped = 1'b1;
        end else begin
          bits |= 24'(v) << (18 - 6 * cnt);
          cnt++;
          if (cnt == 4) begin
            batch.push_back(make_result(bits[23:16], 1'b1, 1'b0));
            batch.push_back(make_result(bits[15:8], 1'b1, 1'b0));
            batch.push_back(make_result(bits[7:0], 1'b1, 1'b0));
            bits = 24'd0;
            cnt = 0;
          end
        end
      end
      if (l) begin
        if (cnt >= 2) batch.push_back(make_result(bits[23:16], 1'b1, 1'b0));
        if (cnt >= 3) batch.push_back(make_result(bits[15:8], 1'b1, 1'b0));
        // A message that ends without a byte still closes with a marker.
        if (batch.size() == 0) batch.push_back(make_result(8'h00, 1'b0, 1'b1));
        else batch[batch.size()-1].last = 1'b1;
      end
    end
    if (l) begin
      clear_codec_state();
    end else begin
      grp_bits = bits;
      grp_cnt = 2'(cnt);
    end
    foreach (batch[i]) expected_out_q.push_back(batch[i]);
  endtask

  // Compares one result transfer with the oldest expectation.
  task automatic check_codec_output();
    result_t got;
    result_t want;
    got = make_result(m_data, m_user, m_last);
    if (expected_out_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: unexpected result data=%h user=%b last=%b",
                 $realtime, got.data, got.valid, got.last);
    end else begin
      want = expected_out_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: mismatch: expected data=%h user=%b last=%b, got %h %b %b",
                   $realtime, want.data, want.valid, want.last,
                   got.data, got.valid, got.last);
      end
    end
  endtask

  // All three channels are observed at the rising edge, with the values that
  // were in place before the edge. A result seen here always belongs to a
  // byte accepted at an earlier edge, so the order of the calls is free.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (s_valid && s_ready) begin
        predict_codec_item(s_data, s_last);
        predicted_items++;
      end
      if (m_valid && m_ready) check_codec_output();
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver pacing
  // ---------------------------------------------------------------------------

  // The receiver stalls at random with a chance of about 22 percent, never while steady is set,
  // and holds off completely for a counted stretch when a hold is requested.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      m_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready <= 1'b0;
    end else if (steady) begin
      m_ready <= 1'b1;
    end else begin
      m_ready <= ($urandom_range(99) >= 22);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one byte and returns at the edge of its transfer. The valid is left
  // high so that the next byte can follow without a gap; whoever ends a burst
  // lowers it in that same step.
  task automatic send_byte(input logic [7:0] value, input logic final_byte);
    while (!steady && $urandom_range(99) < 22) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= value;
    s_last <= final_byte;
    do @(posedge clk_i); while (!s_ready);
    sent_items++;
  endtask

  // Key byte that the block applies to the n-th character of a message, for
  // the settings last written. Every message starts at key byte zero.
  function automatic logic [7:0] stream_key(int unsigned n);
    int unsigned len;
    len = (plan_len > KeyBytes) ? int'(KeyBytes) : int'(plan_len);
    if (len == 0) return 8'h00;
    return plan_key[8*(n % len) +: 8];
  endfunction

  // Sends a whole message with tlast on its final byte. In decrypt mode the
  // plain base64 text is first masked with the key stream.
  task automatic send_message(input byte_q_t text, input bit mask_with_key);
    logic [7:0] b;
    foreach (text[i]) begin
      b = mask_with_key ? (text[i] ^ stream_key(i)) : text[i];
      send_byte(b, i == text.size() - 1);
    end
  endtask

  function automatic byte_q_t text_of(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Lowers the input valid, then waits until every accepted byte has been
  // predicted and every expected result has been seen.
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (expected_out_q.size() != 0 || predicted_items != sent_items)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Registers change only while the block is idle. A decrypted character can
  // cause no result, so a settling wait follows the last result before any
  // write goes out.
  task automatic configure(input mode_e m, input logic [4:0] len,
                           input logic [63:0] lo, input logic [63:0] hi);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(CFG_MODE, {63'd0, m});
    write_reg(CFG_KEY_LENGTH, {59'd0, len});
    write_reg(CFG_KEY_LOW, lo);
    write_reg(CFG_KEY_HIGH, hi);
    cfg_valid <= 1'b0;
    plan_len = len;
    plan_key = {hi, lo};
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty key in encrypt mode: each byte passes through as it is.
  task automatic test_passthrough();
    configure(MODE_ENCRYPT, 5'd0, random_word(), random_word());
    send_message('{8'h00, 8'h5a, 8'hff}, 1'b0);
  endtask

  // Short final groups pick up one or two pad characters, a full group none.
  // A length above the key store size must behave as the full key.
  task automatic test_encode_groups();
    configure(MODE_ENCRYPT, 5'd16, 64'hffff_ffff_ffff_ffff, random_word());
    send_message(text_of("M"), 1'b0);
    send_message(text_of("Ma"), 1'b0);
    send_message(text_of("Man"), 1'b0);
    configure(MODE_ENCRYPT, 5'd31, random_word(), random_word());
    send_message('{8'h00, 8'hff, 8'h80, 8'h7f}, 1'b0);
  endtask

  // Decoding of full and partial groups, the empty end marker, and the
  // permanent stop at a pad or at a character outside the alphabet.
  task automatic test_decode_cases();
    configure(MODE_DECRYPT, 5'd0, random_word(), random_word());
    send_message(text_of("TWFu"), 1'b1);
    send_message(text_of("TQ"), 1'b1);
    send_message(text_of("TWE"), 1'b1);
    send_message('{CharPad}, 1'b1);
    send_message(text_of("QQ=x"), 1'b1);
    send_message('{8'h51, 8'h80, 8'h51, 8'h51}, 1'b1);
  endtask

  // Random plain base64 text, sometimes ending in padding.
  function automatic byte_q_t random_b64_text();
    byte_q_t q;
    int unsigned n;
    int unsigned pads;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) q.push_back(b64_alphabet[$urandom_range(63)]);
    if (n % 4 == 0 && $urandom_range(1) == 1) begin
      pads = $urandom_range(2);
      for (int k = 0; k < pads; k++) q[n-1-k] = CharPad;
    end
    return q;
  endfunction

  // Several phases, each under its own settings. The first few take the
  // extremes of the key length and key value, one phase runs without any
  // idling on either side.
  task automatic test_random_traffic();
    mode_e m;
    logic [4:0] len;
    logic [63:0] lo;
    logic [63:0] hi;
    byte_q_t text;
    int unsigned phase_items;
    int unsigned pick;
    for (int phase = 0; phase < 8; phase++) begin
      m = mode_e'($urandom_range(1));
      len = 5'($urandom_range(31));
      lo = random_word();
      hi = random_word();
      case (phase)
        0: begin m = MODE_ENCRYPT; len = 5'd16; lo = '1; hi = '1; end
        1: begin m = MODE_DECRYPT; len = 5'd0; end
        2: begin m = MODE_ENCRYPT; len = 5'd31; end
        3: begin m = MODE_DECRYPT; len = 5'd1; lo = '0; hi = '0; end
        4: begin m = MODE_DECRYPT; len = 5'd16; end
        default: ;
      endcase
      configure(m, len, lo, hi);
      steady <= (phase == 5);
      phase_items = 0;
      while (phase_items < 20) begin
        text.delete();
        if (m == MODE_ENCRYPT) begin
          for (int i = $urandom_range(1, 10); i > 0; i--) text.push_back(8'($urandom));
        end else begin
          pick = $urandom_range(99);
          if (pick < 75) begin
            text = random_b64_text();
          end else if (pick < 90) begin
            // Well-formed text broken by a pad or a stray byte somewhere.
            text = random_b64_text();
            text[$urandom_range(text.size() - 1)] =
                $urandom_range(1) ? CharPad : 8'($urandom);
          end else begin
            for (int i = $urandom_range(1, 8); i > 0; i--) text.push_back(8'($urandom));
          end
        end
        send_message(text, m == MODE_DECRYPT);
        phase_items += text.size();
      end
    end
    steady <= 1'b0;
  endtask

  // The receiver holds off while the sender keeps offering bytes, so the
  // result queue fills and the input stalls. Later the sender pauses in the
  // middle of a message until all results are out, then finishes it.
  task automatic test_backpressure();
    configure(MODE_ENCRYPT, 5'd7, random_word(), random_word());
    hold_req <= ~hold_req;
    steady <= 1'b1;
    for (int i = 0; i < 13; i++) send_byte(8'($urandom), 1'b0);
    wait_drained();
    for (int i = 0; i < 5; i++) send_byte(8'($urandom), i == 4);
    steady <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_encode_groups();
    test_decode_cases();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_out_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Safety net: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
